// File: rtl/apt_pkg.sv
// Shared constants, command codes and handshake types for the affine point transform.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package apt_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned MAT_DIM  = 4;
  localparam int unsigned N_ENTRY  = MAT_DIM * MAT_DIM;
  localparam int unsigned N_LANES  = 3;
  localparam int unsigned TRANS_ROW = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_POINT = 2'd1,
    CMD_DIR   = 2'd2,
    CMD_IDENT = 2'd3
  } cmd_e;

  typedef struct packed {
    logic s1_valid;
    logic out_ready;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// File: rtl/apt_if.sv
// Valid/ready channel interfaces for command words in and transformed words out.
// Depends on apt_pkg for field widths.
`default_nettype none

interface apt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [apt_pkg::CMD_W-1:0]            cmd;
  logic [apt_pkg::IDX_W-1:0]            entry_index;
  logic signed [apt_pkg::FIELD_W-1:0]   entry_value;
  logic signed [apt_pkg::FIELD_W-1:0]   in_x;
  logic signed [apt_pkg::FIELD_W-1:0]   in_y;
  logic signed [apt_pkg::FIELD_W-1:0]   in_z;

  modport source (output valid, cmd, entry_index, entry_value, in_x, in_y, in_z,
                  input ready);
  modport sink   (input valid, cmd, entry_index, entry_value, in_x, in_y, in_z,
                  output ready);
endinterface

interface apt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [apt_pkg::FIELD_W-1:0]   out_x;
  logic signed [apt_pkg::FIELD_W-1:0]   out_y;
  logic signed [apt_pkg::FIELD_W-1:0]   out_z;
  logic                                 saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/apt_lane.sv
// One output column: three registered fixed-point products, then sum with translation
// and saturate. Depends on apt_pkg.
`default_nettype none

module apt_lane #(
  parameter int unsigned DATA_WIDTH = apt_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = apt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         load_i,
  input  wire logic signed [DATA_WIDTH-1:0] vec_i   [apt_pkg::N_LANES],
  input  wire logic signed [DATA_WIDTH-1:0] col_i   [apt_pkg::N_LANES],
  input  wire logic signed [DATA_WIDTH-1:0] trans_i,
  output logic signed [DATA_WIDTH-1:0]      res_o,
  output logic                              clip_o
);

  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam int unsigned TW = PW - FRAC_BITS;
  localparam int unsigned SW = TW + 2;

  logic signed [PW-1:0]         prod   [apt_pkg::N_LANES];
  logic signed [TW-1:0]         term_d [apt_pkg::N_LANES];
  logic signed [TW-1:0]         term_q [apt_pkg::N_LANES];
  logic signed [DATA_WIDTH-1:0] trans_q;
  logic signed [SW-1:0]         sum;
  logic                         ovf;

  for (genvar r = 0; r < apt_pkg::N_LANES; r++) begin : g_row
    assign prod[r]   = vec_i[r] * col_i[r];
    assign term_d[r] = prod[r][PW-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      term_q  <= term_d;
      trans_q <= trans_i;
    end
  end

  assign sum = SW'(term_q[0]) + SW'(term_q[1]) + SW'(term_q[2]) + SW'(trans_q);
  assign ovf = (sum[SW-1:DATA_WIDTH-1] != {(SW-DATA_WIDTH+1){1'b0}}) &&
               (sum[SW-1:DATA_WIDTH-1] != {(SW-DATA_WIDTH+1){1'b1}});

  always_comb begin
    clip_o = ovf;
    if (!ovf) begin
      res_o = sum[DATA_WIDTH-1:0];
    end else if (sum[SW-1]) begin
      res_o = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// File: rtl/apt_merge.sv
// Output register: gathers the lane results into one word, ORs the clip flags and
// runs the output handshake. Depends on apt_pkg.
`default_nettype none

module apt_merge #(
  parameter int unsigned DATA_WIDTH = apt_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire apt_pkg::pipe_ctl_t            ctl_i,
  input  wire logic signed [DATA_WIDTH-1:0]  res_i  [apt_pkg::N_LANES],
  input  wire logic                          clip_i [apt_pkg::N_LANES],
  output logic                               take_o,
  output logic                               valid_o,
  output logic signed [apt_pkg::FIELD_W-1:0] comp_o [apt_pkg::N_LANES],
  output logic                               sat_o
);

  logic                               valid_q, valid_d;
  logic signed [63:0]                 ext    [apt_pkg::N_LANES];
  logic signed [apt_pkg::FIELD_W-1:0] comp_q [apt_pkg::N_LANES];
  logic signed [apt_pkg::FIELD_W-1:0] comp_d [apt_pkg::N_LANES];
  logic                               sat_q, sat_d;

  assign take_o = !valid_q || ctl_i.out_ready;

  always_comb begin
    valid_d = take_o ? ctl_i.s1_valid : valid_q;
    sat_d   = 1'b0;
    for (int l = 0; l < apt_pkg::N_LANES; l++) begin
      ext[l]    = 64'(res_i[l]);
      comp_d[l] = ext[l][apt_pkg::FIELD_W-1:0];
      sat_d     = sat_d | clip_i[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hold the word while the sink stalls
  always_ff @(posedge clk_i) begin
    if (take_o && ctl_i.s1_valid) begin
      comp_q <= comp_d;
      sat_q  <= sat_d;
    end
  end

  assign valid_o = valid_q;
  assign comp_o  = comp_q;
  assign sat_o   = sat_q;

endmodule

`default_nettype wire

// File: rtl/affine_point_transform.sv
// Affine point transform: 4x4 fixed-point matrix, three column lanes and an output merge.
// Path: an accepted transform word goes through the lane register, then the output register.
// Throughput: one word per cycle unless the sink stalls; lane and output registers set it.
// Matrix writes and identity loads take effect at their accept edge and give no result.
// Reset: pipeline empty, matrix loaded with the identity.
// Depends on apt_pkg, apt_if, apt_lane and apt_merge.
`default_nettype none

module affine_point_transform #(
  parameter int unsigned DATA_WIDTH = apt_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = apt_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  apt_in_if.sink    in_i,
  apt_out_if.source out_o
);

  localparam logic [DATA_WIDTH-1:0] ONE_FX = DATA_WIDTH'(64'd1 << FRAC_BITS);

  function automatic logic [apt_pkg::N_ENTRY-1:0] diag_mask();
    logic [apt_pkg::N_ENTRY-1:0] m;
    m = '0;
    for (int r = 0; r < apt_pkg::MAT_DIM; r++) begin
      m[r * (apt_pkg::MAT_DIM + 1)] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [apt_pkg::N_ENTRY-1:0] DIAG = diag_mask();

  function automatic logic signed [DATA_WIDTH-1:0] fit(
    input logic signed [apt_pkg::FIELD_W-1:0] v
  );
    logic signed [63:0] e;
    e = 64'(v);
    return e[DATA_WIDTH-1:0];
  endfunction

  logic [DATA_WIDTH-1:0]        mat_q [apt_pkg::N_ENTRY];
  logic [DATA_WIDTH-1:0]        mat_d [apt_pkg::N_ENTRY];
  apt_pkg::cmd_e                cmd;
  logic                         accept, xform, s1_en, take;
  logic                         s1_valid_q, s1_valid_d;
  logic signed [DATA_WIDTH-1:0] vec   [apt_pkg::N_LANES];
  logic signed [DATA_WIDTH-1:0] res   [apt_pkg::N_LANES];
  logic                         clip  [apt_pkg::N_LANES];
  logic signed [apt_pkg::FIELD_W-1:0] comp [apt_pkg::N_LANES];
  apt_pkg::pipe_ctl_t           ctl;

  assign cmd    = apt_pkg::cmd_e'(in_i.cmd);
  assign accept = in_i.valid && in_i.ready;
  assign xform  = accept && (cmd == apt_pkg::CMD_POINT || cmd == apt_pkg::CMD_DIR);
  assign s1_en  = !s1_valid_q || take;
  assign in_i.ready = s1_en;

  assign vec[0] = fit(in_i.in_x);
  assign vec[1] = fit(in_i.in_y);
  assign vec[2] = fit(in_i.in_z);

  always_comb begin
    mat_d = mat_q;
    if (accept) begin
      unique case (cmd)
        apt_pkg::CMD_WRITE: mat_d[in_i.entry_index] = fit(in_i.entry_value);
        apt_pkg::CMD_IDENT: begin
          for (int i = 0; i < apt_pkg::N_ENTRY; i++) begin
            mat_d[i] = DIAG[i] ? ONE_FX : '0;
          end
        end
        apt_pkg::CMD_POINT,
        apt_pkg::CMD_DIR: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < apt_pkg::N_ENTRY; i++) begin
        mat_q[i] <= DIAG[i] ? ONE_FX : '0;
      end
      s1_valid_q <= 1'b0;
    end else begin
      mat_q      <= mat_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  assign s1_valid_d = s1_en ? xform : s1_valid_q;

  for (genvar c = 0; c < apt_pkg::N_LANES; c++) begin : g_lane
    logic signed [DATA_WIDTH-1:0] col [apt_pkg::N_LANES];
    logic signed [DATA_WIDTH-1:0] trans;

    for (genvar r = 0; r < apt_pkg::N_LANES; r++) begin : g_col
      assign col[r] = mat_q[r * apt_pkg::MAT_DIM + c];
    end
    assign trans = (cmd == apt_pkg::CMD_POINT) ?
                   mat_q[apt_pkg::TRANS_ROW * apt_pkg::MAT_DIM + c] : '0;

    apt_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .load_i  (s1_en && xform),
      .vec_i   (vec),
      .col_i   (col),
      .trans_i (trans),
      .res_o   (res[c]),
      .clip_o  (clip[c])
    );
  end

  assign ctl.s1_valid  = s1_valid_q;
  assign ctl.out_ready = out_o.ready;

  apt_merge #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .res_i   (res),
    .clip_i  (clip),
    .take_o  (take),
    .valid_o (out_o.valid),
    .comp_o  (comp),
    .sat_o   (out_o.saturated)
  );

  assign out_o.out_x = comp[0];
  assign out_o.out_y = comp[1];
  assign out_o.out_z = comp[2];

  a_ready_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_o.valid && !out_o.ready))
    else $error("input stalled while the pipeline has room");

  a_xform_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xform |=> s1_valid_q)
    else $error("accepted transform word lost before the output stage");

  a_ident_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == apt_pkg::CMD_IDENT) |=>
      (mat_q[0] == ONE_FX && mat_q[1] == '0 && mat_q[apt_pkg::N_ENTRY-1] == ONE_FX))
    else $error("identity load left the matrix wrong");

  a_no_result_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !xform && s1_en) |=> !s1_valid_q)
    else $error("write or identity load produced a result");

endmodule

`default_nettype wire
